// ===== design/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk_i and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define BLAFP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define BLAFP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/blafp_pkg.sv =====
// ----------------------------------------------------------------------------
// blafp_pkg
// Item types and AD type codes for the advertising field parser.
// ----------------------------------------------------------------------------
package blafp_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0]        flags_value;
    logic signed [7:0] tx_power;
    logic [7:0]        le_role;
    logic [15:0]       appearance;
    logic [15:0]       manufacturer_id;
    logic [15:0]       service_data_uuid;
    logic [6:0]        count_uuid16;
    logic [5:0]        count_uuid32;
    logic [3:0]        count_uuid128;
    logic [7:0]        name_offset;
    logic [7:0]        name_length;
    logic [3:0]        complete_mask;
  } out_item_t;

  // Advertising data type codes.
  localparam logic [7:0] AD_FLAGS          = 8'h01;
  localparam logic [7:0] AD_UUID16_PART    = 8'h02;
  localparam logic [7:0] AD_UUID16_FULL    = 8'h03;
  localparam logic [7:0] AD_UUID32_PART    = 8'h04;
  localparam logic [7:0] AD_UUID32_FULL    = 8'h05;
  localparam logic [7:0] AD_UUID128_PART   = 8'h06;
  localparam logic [7:0] AD_UUID128_FULL   = 8'h07;
  localparam logic [7:0] AD_NAME_SHORT     = 8'h08;
  localparam logic [7:0] AD_NAME_FULL      = 8'h09;
  localparam logic [7:0] AD_TX_POWER       = 8'h0A;
  localparam logic [7:0] AD_SVC_DATA16     = 8'h16;
  localparam logic [7:0] AD_APPEARANCE     = 8'h19;
  localparam logic [7:0] AD_LE_ROLE        = 8'h1C;
  localparam logic [7:0] AD_MANUF_SPECIFIC = 8'hFF;

  // Bits of complete_mask.
  localparam int unsigned MASK_UUID16  = 0;
  localparam int unsigned MASK_UUID32  = 1;
  localparam int unsigned MASK_UUID128 = 2;
  localparam int unsigned MASK_NAME    = 3;

endpackage

// ===== design/blafp_out_reg.sv =====
// ----------------------------------------------------------------------------
// blafp_out_reg
// Result register holding one summary item until the consumer takes it.
// ----------------------------------------------------------------------------
module blafp_out_reg (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                load_i,
  input  blafp_pkg::out_item_t item_i,
  output logic                can_load_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output blafp_pkg::out_item_t out_data_o
);

  logic                 valid_q;
  blafp_pkg::out_item_t item_q;

  // A new summary may be written when the slot is empty or drains this cycle.
  assign can_load_o  = !valid_q || out_ready_i;
  assign out_valid_o = valid_q;
  assign out_data_o  = item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= 1'b1;
    end else if (out_ready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      item_q <= item_i;
    end
  end

endmodule

// ===== design/blafp_parser.sv =====
// ----------------------------------------------------------------------------
// blafp_parser
// Length-type-value walker and summary field capture, one byte per step.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module blafp_parser #(
  parameter int unsigned MAX_PAYLOAD = 255
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 step_i,
  input  blafp_pkg::in_item_t  item_i,
  output blafp_pkg::out_item_t summary_o
);

  typedef enum logic [1:0] {
    PH_LENGTH,
    PH_TYPE,
    PH_DATA
  } phase_e;

  localparam logic [7:0] PosLimit = 8'(MAX_PAYLOAD);

  phase_e               phase_q, phase_d;
  logic [7:0]           left_q, left_d;
  logic [7:0]           type_q, type_d;
  logic [1:0]           idx_q, idx_d;     // data index, saturating at two
  logic [7:0]           pos_q, pos_d;
  logic                 stop_q, stop_d;
  logic [7:0]           pend_q, pend_d;
  blafp_pkg::out_item_t sum_q, sum_d;

  logic [7:0]  byte_w;
  logic [7:0]  dlen;
  logic [15:0] word;

  assign byte_w = item_i.data_byte;
  assign dlen   = left_q - 8'd1;
  assign word   = {byte_w, pend_q};

  always_comb begin
    phase_d = phase_q;
    left_d  = left_q;
    type_d  = type_q;
    idx_d   = idx_q;
    stop_d  = stop_q;
    pend_d  = pend_q;
    sum_d   = sum_q;
    pos_d   = (pos_q == 8'hFF) ? pos_q : pos_q + 8'd1;

    if (!stop_q && (pos_q < PosLimit)) begin
      unique case (phase_q)
        PH_TYPE: begin
          type_d  = byte_w;
          left_d  = dlen;
          idx_d   = 2'd0;
          phase_d = (dlen != 8'd0) ? PH_DATA : PH_LENGTH;
          unique case (byte_w)
            blafp_pkg::AD_UUID16_PART, blafp_pkg::AD_UUID16_FULL: begin
              sum_d.count_uuid16 = dlen[7:1];
            end
            blafp_pkg::AD_UUID32_PART, blafp_pkg::AD_UUID32_FULL: begin
              sum_d.count_uuid32 = dlen[7:2];
            end
            blafp_pkg::AD_UUID128_PART, blafp_pkg::AD_UUID128_FULL: begin
              sum_d.count_uuid128 = dlen[7:4];
            end
            blafp_pkg::AD_NAME_SHORT, blafp_pkg::AD_NAME_FULL: begin
              sum_d.name_offset = pos_q + 8'd1;
              sum_d.name_length = dlen;
            end
            default: begin
            end
          endcase
          if (byte_w == blafp_pkg::AD_UUID16_FULL) begin
            sum_d.complete_mask[blafp_pkg::MASK_UUID16] = 1'b1;
          end
          if (byte_w == blafp_pkg::AD_UUID32_FULL) begin
            sum_d.complete_mask[blafp_pkg::MASK_UUID32] = 1'b1;
          end
          if (byte_w == blafp_pkg::AD_UUID128_FULL) begin
            sum_d.complete_mask[blafp_pkg::MASK_UUID128] = 1'b1;
          end
          if (byte_w == blafp_pkg::AD_NAME_FULL) begin
            sum_d.complete_mask[blafp_pkg::MASK_NAME] = 1'b1;
          end
        end
        PH_DATA: begin
          if (idx_q == 2'd0) begin
            unique case (type_q)
              blafp_pkg::AD_FLAGS:    sum_d.flags_value = byte_w;
              blafp_pkg::AD_TX_POWER: sum_d.tx_power    = $signed(byte_w);
              blafp_pkg::AD_LE_ROLE:  sum_d.le_role     = byte_w;
              blafp_pkg::AD_APPEARANCE, blafp_pkg::AD_MANUF_SPECIFIC,
              blafp_pkg::AD_SVC_DATA16: pend_d = byte_w;
              default: begin
              end
            endcase
          end else if (idx_q == 2'd1) begin
            unique case (type_q)
              blafp_pkg::AD_APPEARANCE:     sum_d.appearance        = word;
              blafp_pkg::AD_MANUF_SPECIFIC: sum_d.manufacturer_id   = word;
              blafp_pkg::AD_SVC_DATA16:     sum_d.service_data_uuid = word;
              default: begin
              end
            endcase
          end
          if (idx_q != 2'd2) begin
            idx_d = idx_q + 2'd1;
          end
          left_d = dlen;
          if (dlen == 8'd0) begin
            phase_d = PH_LENGTH;
          end
        end
        default: begin
          // Length byte; zero ends parsing for the rest of the payload.
          if (byte_w == 8'd0) begin
            stop_d = 1'b1;
          end else begin
            left_d  = byte_w;
            phase_d = PH_TYPE;
          end
        end
      endcase
    end
  end

  assign summary_o = sum_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_LENGTH;
      left_q  <= '0;
      type_q  <= '0;
      idx_q   <= '0;
      pos_q   <= '0;
      stop_q  <= 1'b0;
      pend_q  <= '0;
      sum_q   <= '0;
    end else if (step_i) begin
      if (item_i.last_byte) begin
        phase_q <= PH_LENGTH;
        left_q  <= '0;
        type_q  <= '0;
        idx_q   <= '0;
        pos_q   <= '0;
        stop_q  <= 1'b0;
        pend_q  <= '0;
        sum_q   <= '0;
      end else begin
        phase_q <= phase_d;
        left_q  <= left_d;
        type_q  <= type_d;
        idx_q   <= idx_d;
        pos_q   <= pos_d;
        stop_q  <= stop_d;
        pend_q  <= pend_d;
        sum_q   <= sum_d;
      end
    end
  end

  `BLAFP_ASSERT_NEXT(a_packet_restart, step_i && item_i.last_byte,
                     pos_q == 8'd0 && phase_q == PH_LENGTH && !stop_q,
                     "parser state not cleared after the last byte")
  `BLAFP_ASSERT_NEXT(a_pos_advance, step_i && !item_i.last_byte && pos_q != 8'hFF,
                     pos_q == $past(pos_q) + 8'd1,
                     "payload position did not advance by one")

endmodule

// ===== design/ble_advertising_field_parser_core.sv =====
// Order: a byte is registered at its acceptance and parsed from the input register;
// the summary is registered in the result register when the last byte is parsed.
// Throughput: one byte per cycle, set by the single-pass parse between the input
// register and the result register; a last byte waits only while a summary is held.
// Reset: rst_ni clears the parse state, the captured fields and both valid flags.
// ----------------------------------------------------------------------------
// ble_advertising_field_parser_core
// Walks the AD structures of a BLE advertising payload, one byte per item, and
// emits one summary item at the byte marked last.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ble_advertising_field_parser_core #(
  parameter int unsigned MAX_PAYLOAD = 255
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  blafp_pkg::in_item_t  in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output blafp_pkg::out_item_t out_data_o
);

  // Input register: holds the byte that the parser consumes in this cycle.
  logic                 in_valid_q;
  blafp_pkg::in_item_t  in_q;

  // The parser steps whenever a byte is held, except that a last byte must
  // wait until the result register can take its summary.
  logic                 advance;
  logic                 can_load;
  blafp_pkg::out_item_t summary;

  assign advance    = in_valid_q && (!in_q.last_byte || can_load);
  assign in_ready_o = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_q <= in_data_i;
    end
  end

  // The parser updates its state with each byte; its summary output already
  // includes the byte being parsed, so a last byte yields the final summary.
  blafp_parser #(
    .MAX_PAYLOAD(MAX_PAYLOAD)
  ) u_parser (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (advance),
    .item_i   (in_q),
    .summary_o(summary)
  );

  // Result register: parts the consumer from the parser, so bytes of the next
  // payload keep flowing while a summary waits to be taken.
  blafp_out_reg u_out_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (advance && in_q.last_byte),
    .item_i     (summary),
    .can_load_o (can_load),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  `BLAFP_ASSERT_NOW(a_no_summary_overwrite, advance && in_q.last_byte,
                    !out_valid_o || out_ready_i,
                    "summary loaded over one not yet taken")
  `BLAFP_ASSERT_NEXT(a_summary_follows_last, advance && in_q.last_byte,
                     out_valid_o,
                     "no summary after the last byte was parsed")

endmodule

// ===== bench/tb_ble_advertising_field_parser_core.sv =====
// ----------------------------------------------------------------------------
// tb_ble_advertising_field_parser_core
// Self-checking bench for the advertising field parser. A short table of
// hand-built payloads comes first. Random payloads of well-formed AD
// structures follow, with truncation, noise and stop bytes mixed in. Every
// summary item is compared field by field with its table summary or a local model.
// ----------------------------------------------------------------------------
module tb_ble_advertising_field_parser_core;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned PAYLOAD_LIMIT = 255;
  // Each random phase sends payloads until (ph + 1) times this many bytes are accepted.
  localparam int unsigned PHASE_BYTES   = 410;
  localparam int unsigned DRAIN_LIMIT   = 20000;

  // --------------------------------------------------------------------------
  // Clock, reset and the block's ports. Every input holds a known value from
  // time zero onwards.
  // --------------------------------------------------------------------------
  logic                 clk_i       = 1'b0;
  logic                 rst_ni      = 1'b0;
  logic                 in_valid_i  = 1'b0;
  logic                 in_ready_o;
  blafp_pkg::in_item_t  in_data_i   = '0;
  logic                 out_valid_o;
  logic                 out_ready_i = 1'b0;
  blafp_pkg::out_item_t out_data_o;

  always #10 clk_i = ~clk_i;

  ble_advertising_field_parser_core #(
    .MAX_PAYLOAD(PAYLOAD_LIMIT)
  ) u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  // --------------------------------------------------------------------------
  // Local model of the parser. It mirrors the block's parse state and the
  // fields collected so far for the payload that is in flight.
  // --------------------------------------------------------------------------
  typedef enum logic [1:0] {
    EXPECT_LEN,
    EXPECT_TYPE,
    IN_DATA
  } parse_phase_e;

  parse_phase_e         phase_q;
  logic [7:0]           left_q;
  logic [7:0]           ad_type_q;
  logic [7:0]           data_idx_q;
  logic [7:0]           pay_pos_q;
  logic [7:0]           pend_lo_q;
  bit                   stopped_q;
  blafp_pkg::out_item_t fields_q;

  // Summaries that the block still owes us, oldest first.
  blafp_pkg::out_item_t summary_q[$];

  int unsigned  mismatch_count = 0;
  int unsigned  parsed_bytes   = 0;
  int unsigned  idle_pct       = 0;
  int unsigned  stall_pct      = 0;
  int unsigned  hold_cycles_req = 0;

  // Bytes of the random payload currently being sent.
  logic [7:0]   adv_bytes[$];

  function automatic void clear_parser();
    phase_q    = EXPECT_LEN;
    left_q     = '0;
    ad_type_q  = '0;
    data_idx_q = '0;
    pay_pos_q  = '0;
    pend_lo_q  = '0;
    stopped_q  = 1'b0;
    fields_q   = '0;
  endfunction

  // Feeds one accepted byte through the model. Returns 1 and the summary when
  // the byte closes a payload, 0 otherwise.
  function automatic bit parse_advert_byte(input logic [7:0] b, input logic last,
                                           output blafp_pkg::out_item_t summary);
    logic [7:0] dlen;
    summary = '0;
    if (!stopped_q && pay_pos_q < PAYLOAD_LIMIT) begin
      case (phase_q)
        EXPECT_TYPE: begin
          // Counts, the name and the completeness bits are taken from the
          // declared length here, whether or not the data ever arrives.
          ad_type_q  = b;
          left_q     = left_q - 8'd1;
          data_idx_q = '0;
          dlen       = left_q;
          case (b)
            blafp_pkg::AD_UUID16_PART, blafp_pkg::AD_UUID16_FULL: begin
              fields_q.count_uuid16 = dlen[7:1];
              if (b == blafp_pkg::AD_UUID16_FULL) begin
                fields_q.complete_mask[blafp_pkg::MASK_UUID16] = 1'b1;
              end
            end
            blafp_pkg::AD_UUID32_PART, blafp_pkg::AD_UUID32_FULL: begin
              fields_q.count_uuid32 = dlen[7:2];
              if (b == blafp_pkg::AD_UUID32_FULL) begin
                fields_q.complete_mask[blafp_pkg::MASK_UUID32] = 1'b1;
              end
            end
            blafp_pkg::AD_UUID128_PART, blafp_pkg::AD_UUID128_FULL: begin
              fields_q.count_uuid128 = dlen[7:4];
              if (b == blafp_pkg::AD_UUID128_FULL) begin
                fields_q.complete_mask[blafp_pkg::MASK_UUID128] = 1'b1;
              end
            end
            blafp_pkg::AD_NAME_SHORT, blafp_pkg::AD_NAME_FULL: begin
              fields_q.name_offset = pay_pos_q + 8'd1;
              fields_q.name_length = dlen;
              if (b == blafp_pkg::AD_NAME_FULL) begin
                fields_q.complete_mask[blafp_pkg::MASK_NAME] = 1'b1;
              end
            end
            default: ;
          endcase
          phase_q = (left_q != 8'd0) ? IN_DATA : EXPECT_LEN;
        end
        IN_DATA: begin
          // Two-byte values are only written once their second byte is seen.
          if (data_idx_q == 8'd0) begin
            case (ad_type_q)
              blafp_pkg::AD_FLAGS:    fields_q.flags_value = b;
              blafp_pkg::AD_TX_POWER: fields_q.tx_power    = b;
              blafp_pkg::AD_LE_ROLE:  fields_q.le_role     = b;
              blafp_pkg::AD_APPEARANCE, blafp_pkg::AD_MANUF_SPECIFIC,
              blafp_pkg::AD_SVC_DATA16: pend_lo_q = b;
              default: ;
            endcase
          end else if (data_idx_q == 8'd1) begin
            case (ad_type_q)
              blafp_pkg::AD_APPEARANCE:
                fields_q.appearance        = {b, pend_lo_q};
              blafp_pkg::AD_MANUF_SPECIFIC:
                fields_q.manufacturer_id   = {b, pend_lo_q};
              blafp_pkg::AD_SVC_DATA16:
                fields_q.service_data_uuid = {b, pend_lo_q};
              default: ;
            endcase
          end
          if (data_idx_q != 8'hFF) data_idx_q = data_idx_q + 8'd1;
          left_q = left_q - 8'd1;
          if (left_q == 8'd0) phase_q = EXPECT_LEN;
        end
        default: begin
          // A zero length byte ends the parse for the rest of the payload.
          if (b == 8'd0) begin
            stopped_q = 1'b1;
          end else begin
            left_q  = b;
            phase_q = EXPECT_TYPE;
          end
        end
      endcase
    end
    if (pay_pos_q != 8'hFF) pay_pos_q = pay_pos_q + 8'd1;
    if (!last) return 1'b0;
    summary = fields_q;
    clear_parser();
    return 1'b1;
  endfunction

  // --------------------------------------------------------------------------
  // Sender. Each call offers one byte, with random idle cycles in front of it,
  // and returns at the edge that accepts it. The model is updated there.
  // --------------------------------------------------------------------------
  task automatic offer_byte(input logic [7:0] b, input logic last,
                            input bit fixed, input blafp_pkg::out_item_t fixed_sum);
    blafp_pkg::out_item_t predicted;
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      in_data_i  <= '{data_byte: 8'($urandom), last_byte: 1'($urandom)};
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= '{data_byte: b, last_byte: last};
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    parsed_bytes++;
    if (parse_advert_byte(b, last, predicted)) begin
      summary_q.push_back(fixed ? fixed_sum : predicted);
    end
  endtask

  function automatic logic [7:0] known_type();
    case ($urandom_range(13))
      0:       return blafp_pkg::AD_FLAGS;
      1:       return blafp_pkg::AD_UUID16_PART;
      2:       return blafp_pkg::AD_UUID16_FULL;
      3:       return blafp_pkg::AD_UUID32_PART;
      4:       return blafp_pkg::AD_UUID32_FULL;
      5:       return blafp_pkg::AD_UUID128_PART;
      6:       return blafp_pkg::AD_UUID128_FULL;
      7:       return blafp_pkg::AD_NAME_SHORT;
      8:       return blafp_pkg::AD_NAME_FULL;
      9:       return blafp_pkg::AD_TX_POWER;
      10:      return blafp_pkg::AD_SVC_DATA16;
      11:      return blafp_pkg::AD_APPEARANCE;
      12:      return blafp_pkg::AD_LE_ROLE;
      default: return blafp_pkg::AD_MANUF_SPECIFIC;
    endcase
  endfunction

  // Builds one random payload. Most are a handful of well-formed structures
  // of known types with random data, as a real advertiser would send. Some
  // carry a stray byte, an unknown type, a zero length byte or a structure
  // that runs past the end of the payload, and a few are longer than the
  // payload limit so that position saturation is reached.
  task automatic make_payload();
    int unsigned target;
    int unsigned dlen;
    int unsigned roll;
    int unsigned keep;
    logic [7:0]  ad_code;
    adv_bytes.delete();
    target = ($urandom_range(99) < 2) ? $urandom_range(256, 300) : $urandom_range(1, 31);
    while (adv_bytes.size() < target) begin
      roll = $urandom_range(99);
      if (roll < 3) begin
        adv_bytes.push_back(8'h00);
      end else if (roll < 8) begin
        adv_bytes.push_back(8'($urandom));
      end else begin
        ad_code = (roll < 85) ? known_type() : 8'($urandom);
        if ($urandom_range(99) == 0) begin
          // Rare long structure; the longest gives the largest UUID counts.
          dlen = ($urandom_range(3) == 0) ? 254 : $urandom_range(21, 254);
        end else begin
          dlen = $urandom_range(0, 20);
        end
        adv_bytes.push_back(8'(dlen + 1));
        adv_bytes.push_back(ad_code);
        repeat (dlen) adv_bytes.push_back(8'($urandom));
      end
    end
    if ($urandom_range(99) < 15) begin
      keep = $urandom_range(1, adv_bytes.size());
      while (adv_bytes.size() > keep) void'(adv_bytes.pop_back());
    end
  endtask

  // --------------------------------------------------------------------------
  // Directed table. Rows with a typed summary are payloads whose result is
  // plain to see; the others are checked against the local model.
  // --------------------------------------------------------------------------
  typedef struct {
    logic [7:0]           data;
    logic                 last;
    bit                   fixed;
    blafp_pkg::out_item_t summary;
  } stim_row_t;

  localparam int unsigned DIRECTED_ROWS = 25;

  stim_row_t directed_tab [DIRECTED_ROWS] = '{
    // A lone zero byte: nothing captured.
    '{8'h00, 1'b1, 1'b1, '0},
    // One-byte fields at their extremes: flags 0xFF, power -128, role 0x7F.
    '{8'h02, 1'b0, 1'b0, '0},
    '{blafp_pkg::AD_FLAGS, 1'b0, 1'b0, '0},
    '{8'hFF, 1'b0, 1'b0, '0},
    '{8'h02, 1'b0, 1'b0, '0},
    '{blafp_pkg::AD_TX_POWER, 1'b0, 1'b0, '0},
    '{8'h80, 1'b0, 1'b0, '0},
    '{8'h02, 1'b0, 1'b0, '0},
    '{blafp_pkg::AD_LE_ROLE, 1'b0, 1'b0, '0},
    '{8'h7F, 1'b1, 1'b1,
      '{flags_value: 8'hFF, tx_power: -8'sd128, le_role: 8'h7F, default: '0}},
    // A zero length byte first: the flags structure after it is ignored.
    '{8'h00, 1'b0, 1'b0, '0},
    '{8'h02, 1'b0, 1'b0, '0},
    '{blafp_pkg::AD_FLAGS, 1'b0, 1'b0, '0},
    '{8'h55, 1'b1, 1'b1, '0},
    // Empty complete lists and name set every completeness bit; the
    // appearance is cut short by the end of the payload.
    '{8'h01, 1'b0, 1'b0, '0},
    '{blafp_pkg::AD_UUID16_FULL, 1'b0, 1'b0, '0},
    '{8'h01, 1'b0, 1'b0, '0},
    '{blafp_pkg::AD_UUID32_FULL, 1'b0, 1'b0, '0},
    '{8'h01, 1'b0, 1'b0, '0},
    '{blafp_pkg::AD_UUID128_FULL, 1'b0, 1'b0, '0},
    '{8'h01, 1'b0, 1'b0, '0},
    '{blafp_pkg::AD_NAME_FULL, 1'b0, 1'b0, '0},
    '{8'h03, 1'b0, 1'b0, '0},
    '{blafp_pkg::AD_APPEARANCE, 1'b0, 1'b0, '0},
    '{8'h34, 1'b1, 1'b0, '0}
  };

  // --------------------------------------------------------------------------
  // Receiver. Ready is drawn afresh each cycle from the stall rate, except
  // when a long hold-off is requested; that one is counted out here.
  // --------------------------------------------------------------------------
  initial begin : receiver
    int unsigned hold_len;
    forever begin
      @(posedge clk_i);
      if (hold_cycles_req != 0) begin
        hold_len        = hold_cycles_req;
        hold_cycles_req = 0;
        out_ready_i <= 1'b0;
        repeat (hold_len) @(posedge clk_i);
      end else begin
        out_ready_i <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Summary checker.
  // --------------------------------------------------------------------------
  function automatic string summary_text(input blafp_pkg::out_item_t s);
    return $sformatf({"flags=%02h tx=%0d role=%02h app=%04h manuf=%04h svc=%04h ",
                      "c16=%0d c32=%0d c128=%0d noff=%0d nlen=%0d mask=%h"},
                     s.flags_value, s.tx_power, s.le_role, s.appearance,
                     s.manufacturer_id, s.service_data_uuid, s.count_uuid16,
                     s.count_uuid32, s.count_uuid128, s.name_offset, s.name_length,
                     s.complete_mask);
  endfunction

  task automatic report_mismatch(input string why, input blafp_pkg::out_item_t want,
                                 input blafp_pkg::out_item_t got);
    mismatch_count++;
    if (mismatch_count <= 10) begin
      $display("%t: %s", $realtime, why);
      $display("  expected %s", summary_text(want));
      $display("  actual   %s", summary_text(got));
    end
  endtask

  always @(posedge clk_i) begin
    blafp_pkg::out_item_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (summary_q.size() == 0) begin
        report_mismatch("summary item with none expected", '0, out_data_o);
      end else begin
        want = summary_q.pop_front();
        if (want.flags_value       !== out_data_o.flags_value       ||
            want.tx_power          !== out_data_o.tx_power          ||
            want.le_role           !== out_data_o.le_role           ||
            want.appearance        !== out_data_o.appearance        ||
            want.manufacturer_id   !== out_data_o.manufacturer_id   ||
            want.service_data_uuid !== out_data_o.service_data_uuid ||
            want.count_uuid16      !== out_data_o.count_uuid16      ||
            want.count_uuid32      !== out_data_o.count_uuid32      ||
            want.count_uuid128     !== out_data_o.count_uuid128     ||
            want.name_offset       !== out_data_o.name_offset       ||
            want.name_length       !== out_data_o.name_length       ||
            want.complete_mask     !== out_data_o.complete_mask) begin
          report_mismatch("summary item differs", want, out_data_o);
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Main sequence: reset, the directed table, then four random phases with
  // different idle and stall rates. The first random phase opens with a long
  // hold-off on the output so that the block backs up into its input.
  // --------------------------------------------------------------------------
  initial begin : main_seq
    int unsigned drain;
    clear_parser();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < DIRECTED_ROWS; i++) begin
      offer_byte(directed_tab[i].data, directed_tab[i].last,
                 directed_tab[i].fixed, directed_tab[i].summary);
    end

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          idle_pct        = 0;
          stall_pct       = 0;
          hold_cycles_req = 400;
        end
        1: begin
          idle_pct  = 54;
          stall_pct = 0;
        end
        2: begin
          idle_pct  = 0;
          stall_pct = 54;
        end
        default: begin
          idle_pct  = 33;
          stall_pct = 33;
        end
      endcase
      while (parsed_bytes < (ph + 1) * PHASE_BYTES) begin
        make_payload();
        for (int k = 0; k < adv_bytes.size(); k++) begin
          offer_byte(adv_bytes[k], k == adv_bytes.size() - 1, 1'b0, '0);
        end
      end
    end
    in_valid_i <= 1'b0;

    // Let the outstanding summaries come out, then keep watching the output to catch
    // anything the block should not have sent.
    drain = 0;
    while (summary_q.size() != 0 && drain < DRAIN_LIMIT) begin
      @(posedge clk_i);
      drain++;
    end
    repeat (8) @(posedge clk_i);
    mismatch_count += summary_q.size();

    if (mismatch_count == 0) begin
      $display("ble_advertising_field_parser_core: match");
    end else begin
      $display("ble_advertising_field_parser_core: mismatch");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin : watchdog
    #10_000_000;
    $display("ble_advertising_field_parser_core: mismatch");
    $finish;
  end

endmodule
